[src/palette_lookup_or_allocate_macros.svh]
// Assertion macros shared by the palette lookup block
`ifndef PALETTE_LOOKUP_OR_ALLOCATE_MACROS_SVH
`define PALETTE_LOOKUP_OR_ALLOCATE_MACROS_SVH

// cond must hold at every clock edge out of reset
`define PLO_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// cons must hold in the same cycle as ante
`define PLO_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// cons must hold in the cycle after ante
`define PLO_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/plo_pkg.sv]
// Package: constants, types and helpers of the palette lookup block
`timescale 1ns / 1ps

package plo_pkg;

    localparam int TABLE_ENTRIES_DEF = 32;
    localparam int PAIR_BASE         = 64;
    localparam int FIRST_SLOT        = 32;

    localparam int RGB_W      = 24;
    localparam int COMP_W     = 8;
    localparam int PAIR_W     = 7;
    localparam int SLOT_W     = 15;
    localparam int LEVEL_W    = 10;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 15;

    localparam logic [SLOT_W-1:0] COLOR_LIMIT_RST = SLOT_W'(256);
    localparam logic [SLOT_W-1:0] FIRST_SLOT_VAL  = SLOT_W'(FIRST_SLOT);
    localparam logic [PAIR_W-1:0] PAIR_LO         = PAIR_W'(PAIR_BASE % 128);

    // c*1000/255 == c*200/51; 200*ceil(2^24/51) keeps the error below 1/51
    localparam int SCALE_PROD_W = 34;
    localparam int SCALE_SHIFT  = 24;
    localparam logic [SCALE_PROD_W-1:0] SCALE_MUL = SCALE_PROD_W'(65793200);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLE      = 1'b0,
        CFG_COLOR_LIMIT = 1'b1
    } cfg_reg_t;

    // request token walking down the cell chain
    typedef struct packed {
        logic              vld;
        logic              alloc_ok;
        logic              hit;
        logic              alloc;
        logic [RGB_W-1:0]  rgb;
        logic [PAIR_W-1:0] pair;
    } cell_tok_t;

    function automatic logic [LEVEL_W-1:0] scale_level(input logic [COMP_W-1:0] comp);
        logic [SCALE_PROD_W-1:0] prod;
        prod = SCALE_PROD_W'(comp) * SCALE_MUL;
        return prod[SCALE_SHIFT +: LEVEL_W];
    endfunction

endpackage

[src/plo_req_if.sv]
// Request channel: one RGB color per beat
`timescale 1ns / 1ps

interface plo_req_if;
    logic                     valid;
    logic                     ready;
    logic [plo_pkg::RGB_W-1:0] rgb;

    modport source (output valid, output rgb, input ready);
    modport sink   (input valid, input rgb, output ready);
endinterface

[src/plo_rsp_if.sv]
// Response channel: pair number and allocation data per beat
`timescale 1ns / 1ps

interface plo_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [plo_pkg::PAIR_W-1:0]  pair_number;
    logic                        allocated;
    logic [plo_pkg::SLOT_W-1:0]  color_slot;
    logic [plo_pkg::LEVEL_W-1:0] red_level;
    logic [plo_pkg::LEVEL_W-1:0] green_level;
    logic [plo_pkg::LEVEL_W-1:0] blue_level;

    modport source (output valid, output pair_number, output allocated, output color_slot,
                    output red_level, output green_level, output blue_level, input ready);
    modport sink   (input valid, input pair_number, input allocated, input color_slot,
                    input red_level, input green_level, input blue_level, output ready);
endinterface

[src/plo_cfg_if.sv]
// Configuration write channel: register index and data per beat
`timescale 1ns / 1ps

interface plo_cfg_if;
    logic                           valid;
    logic                           ready;
    plo_pkg::cfg_reg_t              index;
    logic [plo_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[src/plo_cell.sv]
// One table cell: holds an entry, compares the passing token, claims it on a miss
`timescale 1ns / 1ps

module plo_cell #(
    parameter int INDEX = 0
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               adv,
    input  logic               upstream_full,
    input  plo_pkg::cell_tok_t tok_in,
    output plo_pkg::cell_tok_t tok_out,
    output logic               entry_full
);

    localparam int PW = plo_pkg::PAIR_W;
    localparam logic [PW-1:0] CELL_PAIR = PW'((plo_pkg::PAIR_BASE + INDEX) % 128);

    plo_pkg::cell_tok_t             tok_reg;
    plo_pkg::cell_tok_t             tok_next;
    logic                           full_reg;
    logic                           full_next;
    logic [plo_pkg::RGB_W-1:0]      color_reg;
    logic                           match;
    logic                           take;

    // only the first empty cell can claim, since entries fill in order
    assign match = tok_in.vld && full_reg && !tok_in.hit && (color_reg == tok_in.rgb);
    assign take  = tok_in.vld && tok_in.alloc_ok && !tok_in.hit && !tok_in.alloc
                   && !full_reg && upstream_full;

    always_comb
    begin
        tok_next  = tok_in;
        full_next = full_reg | take;
        if (match)
        begin
            tok_next.hit  = 1'b1;
            tok_next.pair = CELL_PAIR;
        end
        if (take)
        begin
            tok_next.alloc = 1'b1;
            tok_next.pair  = CELL_PAIR;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg  <= '0;
            full_reg <= 1'b0;
        end
        else if (adv)
        begin
            tok_reg  <= tok_next;
            full_reg <= full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && take)
        begin
            color_reg <= tok_in.rgb;
        end
    end

    assign tok_out    = tok_reg;
    assign entry_full = full_reg;

endmodule

[src/palette_lookup_or_allocate.sv]
// Top level: color table lookup or allocate built from a chain of cells
//
//  channel | dir | payload                                    | beat when
//  --------+-----+--------------------------------------------+------------------
//  req     | in  | rgb                                        | valid && ready
//  rsp     | out | pair_number allocated color_slot *_level   | valid && ready
//  cfg     | in  | index data                                 | valid && ready
//
// A request walks the cell chain one cell per cycle and is then loaded into
// the response register; one request is in flight. A stalled response freezes
// the chain once a token sits in the last cell. A new request is taken the cycle
// after the response register is loaded, even while that response still waits.
// Reset empties the table and restores the registers; cfg is always ready.
`timescale 1ns / 1ps
`include "palette_lookup_or_allocate_macros.svh"

module palette_lookup_or_allocate #(
    parameter int TABLE_ENTRIES = plo_pkg::TABLE_ENTRIES_DEF
) (
    input logic          clk,
    input logic          rst_n,
    plo_cfg_if.sink      cfg,
    plo_req_if.sink      req,
    plo_rsp_if.source    rsp
);

    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam int PW    = plo_pkg::PAIR_W;
    localparam int SW    = plo_pkg::SLOT_W;
    localparam int LW    = plo_pkg::LEVEL_W;

    plo_pkg::cell_tok_t            tok_q [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0]      full_vec;
    logic [TABLE_ENTRIES-1:0]      tok_vld;
    plo_pkg::cell_tok_t            inject;
    plo_pkg::cell_tok_t            exit_tok;
    logic                          adv;
    logic                          out_load;
    logic                          req_beat;

    logic                          enable_reg,      enable_next;
    logic [SW-1:0]                 color_limit_reg, color_limit_next;
    logic [CNT_W-1:0]              count_reg,       count_next;
    logic [SW-1:0]                 next_slot_reg,   next_slot_next;
    logic                          busy_reg,        busy_next;
    logic                          out_valid_reg,   out_valid_next;

    logic [PW-1:0]                 pair_reg,        pair_next;
    logic                          alloc_reg,       alloc_next;
    logic [SW-1:0]                 slot_reg,        slot_next;
    logic [LW-1:0]                 red_reg,         red_next;
    logic [LW-1:0]                 green_reg,       green_next;
    logic [LW-1:0]                 blue_reg,        blue_next;
    logic [PW-1:0]                 last_pair;

    assign exit_tok = tok_q[TABLE_ENTRIES-1];
    assign out_load = exit_tok.vld && (!out_valid_reg || rsp.ready);
    assign adv      = !exit_tok.vld || out_load;
    assign req_beat = req.valid && req.ready;

    assign req.ready = !busy_reg;
    assign cfg.ready = 1'b1;

    // room is decided once at entry; state only moves when the token leaves
    always_comb
    begin
        inject          = '0;
        inject.vld      = req_beat;
        inject.rgb      = req.rgb;
        inject.alloc_ok = enable_reg && (count_reg < CNT_W'(TABLE_ENTRIES))
                          && (next_slot_reg < color_limit_reg);
    end

    generate
        for (genvar i = 0; i < TABLE_ENTRIES; i++)
        begin : g_cell
            if (i == 0)
            begin : g_head
                plo_cell #(.INDEX(i)) u_cell (
                    .clk           (clk),
                    .rst_n         (rst_n),
                    .adv           (adv),
                    .upstream_full (1'b1),
                    .tok_in        (inject),
                    .tok_out       (tok_q[i]),
                    .entry_full    (full_vec[i])
                );
            end
            else
            begin : g_body
                plo_cell #(.INDEX(i)) u_cell (
                    .clk           (clk),
                    .rst_n         (rst_n),
                    .adv           (adv),
                    .upstream_full (full_vec[i-1]),
                    .tok_in        (tok_q[i-1]),
                    .tok_out       (tok_q[i]),
                    .entry_full    (full_vec[i])
                );
            end
            assign tok_vld[i] = tok_q[i].vld;
        end
    endgenerate

    always_comb
    begin
        enable_next      = enable_reg;
        color_limit_next = color_limit_reg;
        if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                plo_pkg::CFG_ENABLE:      enable_next      = cfg.data[0];
                plo_pkg::CFG_COLOR_LIMIT: color_limit_next = cfg.data;
                default:                  ;
            endcase
        end
    end

    assign last_pair = plo_pkg::PAIR_LO + PW'(count_reg) - PW'(1);

    always_comb
    begin
        pair_next      = '0;
        alloc_next     = 1'b0;
        slot_next      = '0;
        red_next       = '0;
        green_next     = '0;
        blue_next      = '0;
        count_next     = count_reg;
        next_slot_next = next_slot_reg;
        if (enable_reg)
        begin
            if (exit_tok.hit)
            begin
                pair_next = exit_tok.pair;
            end
            else if (exit_tok.alloc)
            begin
                pair_next  = exit_tok.pair;
                alloc_next = 1'b1;
                slot_next  = next_slot_reg;
                red_next   = plo_pkg::scale_level(exit_tok.rgb[23:16]);
                green_next = plo_pkg::scale_level(exit_tok.rgb[15:8]);
                blue_next  = plo_pkg::scale_level(exit_tok.rgb[7:0]);
                if (out_load)
                begin
                    count_next     = count_reg + CNT_W'(1);
                    next_slot_next = next_slot_reg + SW'(1);
                end
            end
            else if (count_reg != '0)
            begin
                pair_next = last_pair;
            end
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        if (req_beat)
        begin
            busy_next = 1'b1;
        end
        else if (out_load)
        begin
            busy_next = 1'b0;
        end
        out_valid_next = out_load ? 1'b1 : (rsp.ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg      <= 1'b0;
            color_limit_reg <= plo_pkg::COLOR_LIMIT_RST;
            count_reg       <= '0;
            next_slot_reg   <= plo_pkg::FIRST_SLOT_VAL;
            busy_reg        <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            enable_reg      <= enable_next;
            color_limit_reg <= color_limit_next;
            count_reg       <= count_next;
            next_slot_reg   <= next_slot_next;
            busy_reg        <= busy_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            pair_reg  <= pair_next;
            alloc_reg <= alloc_next;
            slot_reg  <= slot_next;
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.pair_number = pair_reg;
    assign rsp.allocated   = alloc_reg;
    assign rsp.color_slot  = slot_reg;
    assign rsp.red_level   = red_reg;
    assign rsp.green_level = green_reg;
    assign rsp.blue_level  = blue_reg;

    `PLO_ASSERT_ALWAYS(a_one_token, $countones(tok_vld) <= 1, "more than one token in chain")
    `PLO_ASSERT_ALWAYS(a_count_max, count_reg <= CNT_W'(TABLE_ENTRIES), "entry count overflow")
    `PLO_ASSERT_IMPL(a_hit_xor_alloc, exit_tok.vld, !(exit_tok.hit && exit_tok.alloc), "token both hit and allocated")
    `PLO_ASSERT_NEXT(a_alloc_count, out_load && enable_reg && exit_tok.alloc && !exit_tok.hit, count_reg == $past(count_reg) + CNT_W'(1), "entry count did not advance on allocation")
    `PLO_ASSERT_IMPL(a_busy_token, $countones(tok_vld) != 0, busy_reg, "token in chain while idle")

endmodule

[tb/tb_top.sv]
// Self-checking testbench for the palette lookup / allocate color table
`timescale 1ns / 1ps

module tb_top;

    localparam int RGB_W      = plo_pkg::RGB_W;
    localparam int COMP_W     = plo_pkg::COMP_W;
    localparam int PAIR_W     = plo_pkg::PAIR_W;
    localparam int SLOT_W     = plo_pkg::SLOT_W;
    localparam int LEVEL_W    = plo_pkg::LEVEL_W;
    localparam int CFG_DATA_W = plo_pkg::CFG_DATA_W;

    localparam int CLK_HALF      = 4;
    localparam int CHAIN_LATENCY = plo_pkg::TABLE_ENTRIES_DEF + 1;
    localparam int HOLD_CYCLES   = 300;
    localparam int QUIET_LIMIT   = 4000;
    localparam int IDLE_PCT      = 16;

    typedef struct packed {
        logic [PAIR_W-1:0]  pair;
        logic               alloc;
        logic [SLOT_W-1:0]  slot;
        logic [LEVEL_W-1:0] red;
        logic [LEVEL_W-1:0] green;
        logic [LEVEL_W-1:0] blue;
    } color_answer_t;

    logic clk;
    logic rst_n;

    plo_cfg_if cfg_if ();
    plo_req_if req_if ();
    plo_rsp_if rsp_if ();

    palette_lookup_or_allocate dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_if),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    // palette shadow state
    logic [RGB_W-1:0]  stored_rgb [plo_pkg::TABLE_ENTRIES_DEF];
    int                stored_count;
    logic [SLOT_W-1:0] free_slot;
    logic              lookups_on;
    logic [SLOT_W-1:0] slot_limit;

    color_answer_t pending_answers [$];

    logic idle_on;
    logic hold_pending;
    int   errors;
    int   quiet_cycles;
    int   n_sent, n_alloc, n_hit, n_refused, n_disabled, n_reg_writes;

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    function automatic logic [LEVEL_W-1:0] to_level(input logic [COMP_W-1:0] comp);
        int v;
        v = int'(comp) * 1000 / 255;
        return LEVEL_W'(v);
    endfunction

    // next answer for one accepted color; updates the shadow palette
    function automatic color_answer_t lookup_color(input logic [RGB_W-1:0] rgb);
        color_answer_t a;
        a = '0;
        if (!lookups_on)
        begin
            n_disabled++;
            return a;
        end
        for (int i = 0; i < stored_count; i++)
        begin
            if (stored_rgb[i] == rgb)
            begin
                a.pair = PAIR_W'(plo_pkg::PAIR_BASE + i);
                n_hit++;
                return a;
            end
        end
        if (stored_count >= plo_pkg::TABLE_ENTRIES_DEF || free_slot >= slot_limit)
        begin
            if (stored_count > 0)
                a.pair = PAIR_W'(plo_pkg::PAIR_BASE + stored_count - 1);
            n_refused++;
            return a;
        end
        stored_rgb[stored_count] = rgb;
        a.pair  = PAIR_W'(plo_pkg::PAIR_BASE + stored_count);
        a.alloc = 1'b1;
        a.slot  = free_slot;
        a.red   = to_level(rgb[23:16]);
        a.green = to_level(rgb[15:8]);
        a.blue  = to_level(rgb[7:0]);
        stored_count++;
        free_slot = free_slot + SLOT_W'(1);
        n_alloc++;
        return a;
    endfunction

    // mostly hits and near misses on stored colors, some extremes, rest fresh
    function automatic logic [RGB_W-1:0] pick_color();
        int r;
        logic [RGB_W-1:0] c;
        r = $urandom_range(99);
        if (stored_count > 0 && r < 45)
            c = stored_rgb[$urandom_range(stored_count - 1)];
        else if (stored_count > 0 && r < 55)
            c = stored_rgb[$urandom_range(stored_count - 1)] ^ (24'h1 << $urandom_range(23));
        else if (r < 62)
        begin
            case ($urandom_range(4))
                0: c = 24'h000000;
                1: c = 24'hFFFFFF;
                2: c = 24'hFF0000;
                3: c = 24'h00FF00;
                default: c = 24'h0000FF;
            endcase
        end
        else
            c = RGB_W'($urandom());
        return c;
    endfunction

    task automatic send_color(input logic [RGB_W-1:0] rgb);
        if (idle_on && $urandom_range(99) < IDLE_PCT)
        begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        req_if.valid <= 1'b1;
        req_if.rgb   <= rgb;
        do @(posedge clk); while (!req_if.ready);
        pending_answers.push_back(lookup_color(rgb));
        n_sent++;
    endtask

    task automatic wait_idle();
        req_if.valid <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge clk);
    endtask

    // both registers, back to back, only once every answer is in
    task automatic set_config(input logic [CFG_DATA_W-1:0] en_word,
                              input logic [CFG_DATA_W-1:0] limit);
        wait_idle();
        cfg_if.valid <= 1'b1;
        cfg_if.index <= plo_pkg::CFG_ENABLE;
        cfg_if.data  <= en_word;
        do @(posedge clk); while (!cfg_if.ready);
        lookups_on = en_word[0];
        cfg_if.index <= plo_pkg::CFG_COLOR_LIMIT;
        cfg_if.data  <= limit;
        do @(posedge clk); while (!cfg_if.ready);
        slot_limit = limit;
        cfg_if.valid <= 1'b0;
        n_reg_writes += 2;
    endtask

    task automatic send_random(input int count);
        repeat (count) send_color(pick_color());
    endtask

    // reset state: lookups off, every answer is zero
    task automatic test_disabled_at_reset();
        send_color(24'h000000);
        send_color(24'hFFFFFF);
        send_color(24'h123456);
    endtask

    // empty palette and no slot: pair 0
    task automatic test_no_slot_empty();
        set_config(15'h7FFF, 15'h0000);
        send_color(24'hFFFFFF);
        set_config(15'h0001, SLOT_W'(plo_pkg::FIRST_SLOT));
        send_color(24'h000000);
    endtask

    // two slots only, then refusal returns the last pair
    task automatic test_slot_limit();
        set_config(15'h0001, SLOT_W'(plo_pkg::FIRST_SLOT + 2));
        send_color(24'h000000);
        send_color(24'hFFFFFF);
        send_color(24'hFF0000);
        send_color(24'h000000);
        send_color(24'hFFFFFF);
    endtask

    task automatic test_primary_colors();
        set_config(15'h0001, 15'h7FFF);
        send_color(24'hFF0000);
        send_color(24'h00FF00);
        send_color(24'h0000FF);
        send_color(24'h010203);
        send_color(24'h7F8081);
        send_color(24'hFF0000);
        send_color(24'h00FF01);
    endtask

    // disabled with a populated palette: no hit, no allocation; then enabled again
    task automatic test_enable_toggle();
        set_config(15'h7FFE, 15'h7FFF);
        send_color(24'h0000FF);
        send_color(24'h5A5A5A);
        set_config(15'h0001, 15'h7FFF);
        send_color(24'h5A5A5A);
    endtask

    // slots run out before the palette fills
    task automatic test_random_slot_limit();
        set_config(15'h0001, free_slot + SLOT_W'(5));
        send_random(150);
    endtask

    // no idling on either side; palette fills up, then stays full
    task automatic test_fill_palette_burst();
        set_config(15'h0001, 15'h7FFF);
        idle_on = 1'b0;
        send_random(200);
        wait_idle();
        idle_on = 1'b1;
    endtask

    task automatic test_output_backpressure();
        hold_pending <= 1'b1;
        send_random(40);
    endtask

    task automatic test_random_settings();
        logic [CFG_DATA_W-1:0] w;
        logic [CFG_DATA_W-1:0] lim;
        repeat (7)
        begin
            w    = CFG_DATA_W'($urandom());
            w[0] = ($urandom_range(99) < 80);
            case ($urandom_range(3))
                0: lim = '0;
                1: lim = '1;
                2: lim = plo_pkg::COLOR_LIMIT_RST;
                default: lim = CFG_DATA_W'($urandom());
            endcase
            set_config(w, lim);
            send_random(50);
        end
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    // response side: random idling, plus one long hold-off on request
    initial
    begin : rsp_ready_drive
        rsp_if.ready = 1'b0;
        hold_pending = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_pending)
            begin
                hold_pending <= 1'b0;
                rsp_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                rsp_if.ready <= !(idle_on && $urandom_range(99) < IDLE_PCT);
                @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin : rsp_check
        color_answer_t want;
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            if (pending_answers.size() == 0)
            begin
                $error("response beat with no request pending, pair %0d", rsp_if.pair_number);
                errors++;
            end
            else
            begin
                want = pending_answers.pop_front();
                check_field("pair_number", int'(want.pair), int'(rsp_if.pair_number));
                check_field("allocated", int'(want.alloc), int'(rsp_if.allocated));
                check_field("color_slot", int'(want.slot), int'(rsp_if.color_slot));
                check_field("red_level", int'(want.red), int'(rsp_if.red_level));
                check_field("green_level", int'(want.green), int'(rsp_if.green_level));
                check_field("blue_level", int'(want.blue), int'(rsp_if.blue_level));
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)
            || (cfg_if.valid && cfg_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $error("no beat on any channel for %0d cycles", quiet_cycles);
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        req_if.valid = 1'b0;
        req_if.rgb   = '0;
        cfg_if.valid = 1'b0;
        cfg_if.index = plo_pkg::CFG_ENABLE;
        cfg_if.data  = '0;
        idle_on      = 1'b1;
        errors       = 0;
        quiet_cycles = 0;
        n_sent = 0; n_alloc = 0; n_hit = 0; n_refused = 0; n_disabled = 0; n_reg_writes = 0;
        for (int i = 0; i < plo_pkg::TABLE_ENTRIES_DEF; i++)
            stored_rgb[i] = '0;
        stored_count = 0;
        free_slot    = plo_pkg::FIRST_SLOT_VAL;
        lookups_on   = 1'b0;
        slot_limit   = plo_pkg::COLOR_LIMIT_RST;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_disabled_at_reset();
        test_no_slot_empty();
        test_slot_limit();
        test_primary_colors();
        test_enable_toggle();
        test_random_slot_limit();
        test_fill_palette_burst();
        test_output_backpressure();
        test_random_settings();

        wait_idle();
        repeat (2 * CHAIN_LATENCY) @(posedge clk);

        $display("summary: %0d color requests: %0d allocated, %0d hits, %0d refused, %0d disabled",
                 n_sent, n_alloc, n_hit, n_refused, n_disabled);
        $display("summary: %0d register writes, slot limit 0..32767, %0d-cycle response hold-off",
                 n_reg_writes, HOLD_CYCLES);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

[palette_lookup_or_allocate.f]
+incdir+src
src/plo_pkg.sv
src/plo_req_if.sv
src/plo_rsp_if.sv
src/plo_cfg_if.sv
src/plo_cell.sv
src/palette_lookup_or_allocate.sv
tb/tb_top.sv
